// ===== hw/rtl/call_frame_stack_with_bindings_top_assert.svh =====
// assertion macros for the call frame stack
`ifndef CALL_FRAME_STACK_WITH_BINDINGS_TOP_ASSERT_SVH
`define CALL_FRAME_STACK_WITH_BINDINGS_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define CFSB_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// consequent must hold in the cycle after the antecedent
`define CFSB_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define CFSB_ASSERT(label, prop, msg)
`define CFSB_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

// ===== hw/rtl/cfsb_pkg.sv =====
package cfsb_pkg;

	localparam int FRAME_DEPTH_DEF     = 64;
	localparam int SLOTS_PER_FRAME_DEF = 16;

	localparam int OPCODE_W  = 3;
	localparam int OFFSET_W  = 24;
	localparam int INDEX_W   = 8;
	localparam int VALUE_W   = 32;
	localparam int STATUS_W  = 2;

	typedef enum logic [OPCODE_W-1:0] {
		OP_PUSH     = 3'd0,
		OP_POP      = 3'd1,
		OP_READ     = 3'd2,
		OP_WRITE    = 3'd3,
		OP_READ_OFS = 3'd4
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK      = 2'd0,
		ST_STACK   = 2'd1,
		ST_RANGE   = 2'd2,
		ST_UNBOUND = 2'd3
	} status_t;

	// a slot holding all ones reads as unbound
	localparam logic [VALUE_W-1:0] UNBOUND_MARK = '1;

endpackage

// ===== hw/rtl/cfsb_if.sv =====
// command channel
interface cfsb_cmd_if import cfsb_pkg::*;;
	logic                       valid;
	logic                       ready;
	logic [OPCODE_W-1:0]        opcode;
	logic [OFFSET_W-1:0]        frame_offset;
	logic [INDEX_W-1:0]         binding_index;
	logic signed [VALUE_W-1:0]  binding_value;

	modport source (output valid, output opcode, output frame_offset,
		output binding_index, output binding_value, input ready);
	modport sink (input valid, input opcode, input frame_offset,
		input binding_index, input binding_value, output ready);
endinterface

// response channel
interface cfsb_rsp_if import cfsb_pkg::*;;
	logic                       valid;
	logic                       ready;
	logic [STATUS_W-1:0]        status;
	logic signed [VALUE_W-1:0]  read_value;

	modport source (output valid, output status, output read_value, input ready);
	modport sink (input valid, input status, input read_value, output ready);
endinterface

// ===== hw/rtl/call_frame_stack_with_bindings_top.sv =====
// Call frame stack with frame-local bindings. Commands arrive on cmd (push frame, pop frame,
// read binding, write binding, read return offset) and each one yields exactly one response on
// rsp, in order. One command is taken every cycle as long as responses drain. A command's
// response passes through the stage 1 registers and then the response register before it is
// offered on rsp, because the offset, bound flag and slot value stores are memories with
// registered read data. All state changes (frame count, the
// pushed offset, bound flags, slot values) commit at the command's transfer edge, so a command
// always sees the effect of the one before it with no forwarding. A push clears the new frame's
// bound flags in one write of the flag row. Error order: empty or full stack first, then slot
// index range, then unbound slot (a bound slot holding all ones also reads as unbound). Unused
// opcodes return ok with a zero value and change nothing. No clearing pass after reset.
`include "call_frame_stack_with_bindings_top_assert.svh"

module call_frame_stack_with_bindings_top import cfsb_pkg::*; #(
	parameter int FRAME_DEPTH     = FRAME_DEPTH_DEF,
	parameter int SLOTS_PER_FRAME = SLOTS_PER_FRAME_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	cfsb_cmd_if.sink   cmd,
	cfsb_rsp_if.source rsp
);

	localparam int CW = $clog2(FRAME_DEPTH + 1);
	localparam int AW = $clog2(FRAME_DEPTH);
	localparam int SW = (SLOTS_PER_FRAME > 1) ? $clog2(SLOTS_PER_FRAME) : 1;

	// frame count and the three stores
	logic [CW-1:0]      frame_count_q;
	logic [OFFSET_W-1:0] offsets_mem [FRAME_DEPTH];
	logic [SLOTS_PER_FRAME-1:0] flags_mem [FRAME_DEPTH];
	logic [VALUE_W-1:0] values_mem [FRAME_DEPTH][SLOTS_PER_FRAME];

	// decode at the transfer edge
	logic          cmd_fire;
	logic          is_push, is_pop, is_rd, is_wr, is_ofs, is_known;
	logic          stack_full, stack_empty, idx_oob;
	logic          err_stack, err_range;
	logic          do_push, do_pop, do_wr, do_rd, do_ofs;
	logic [CW-1:0] cnt_m1;
	logic [AW-1:0] top_addr, new_addr;
	logic [SW-1:0] slot;

	// stage 1: registered memory reads plus the early status
	logic                valid_s1;
	logic                rd_s1, ofs_s1;
	status_t             err_s1;
	logic [OFFSET_W-1:0] ofs_rd_s1;
	logic [VALUE_W-1:0]  val_rd_s1;
	logic                flag_rd_s1;

	// response register
	logic               rsp_valid_q;
	status_t            status_q;
	logic [VALUE_W-1:0] value_q;
	logic               out_free, s1_adv;

	assign out_free = !rsp_valid_q || rsp.ready;
	assign s1_adv   = valid_s1 && out_free;
	assign cmd.ready = !valid_s1 || out_free;
	assign cmd_fire  = cmd.valid && cmd.ready;

	always_comb begin
		is_push  = (cmd.opcode == OP_PUSH);
		is_pop   = (cmd.opcode == OP_POP);
		is_rd    = (cmd.opcode == OP_READ);
		is_wr    = (cmd.opcode == OP_WRITE);
		is_ofs   = (cmd.opcode == OP_READ_OFS);
		is_known = is_push || is_pop || is_rd || is_wr || is_ofs;

		stack_full  = (frame_count_q == CW'(FRAME_DEPTH));
		stack_empty = (frame_count_q == '0);
		idx_oob     = ({1'b0, cmd.binding_index} >= (INDEX_W + 1)'(SLOTS_PER_FRAME));

		cnt_m1   = frame_count_q - CW'(1);
		top_addr = cnt_m1[AW-1:0];
		new_addr = frame_count_q[AW-1:0];
		slot     = cmd.binding_index[SW-1:0];

		// stack check goes before the slot range check
		err_stack = is_push ? stack_full : (is_known && stack_empty);
		err_range = (is_rd || is_wr) && !err_stack && idx_oob;

		do_push = cmd_fire && is_push && !err_stack;
		do_pop  = cmd_fire && is_pop && !err_stack;
		do_ofs  = cmd_fire && is_ofs && !err_stack;
		do_wr   = cmd_fire && is_wr && !err_stack && !err_range;
		do_rd   = cmd_fire && is_rd && !err_stack && !err_range;
	end

	// frame count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_count_q <= '0;
		end else if (do_push) begin
			frame_count_q <= frame_count_q + CW'(1);
		end else if (do_pop) begin
			frame_count_q <= cnt_m1;
		end
	end

	// return offset memory
	always_ff @(posedge clk) begin
		if (do_push) begin
			offsets_mem[new_addr] <= cmd.frame_offset;
		end
		if (do_ofs) begin
			ofs_rd_s1 <= offsets_mem[top_addr];
		end
	end

	// bound flag memory, a push clears the whole row
	always_ff @(posedge clk) begin
		if (do_push) begin
			flags_mem[new_addr] <= '0;
		end else if (do_wr) begin
			flags_mem[top_addr][slot] <= 1'b1;
		end
		if (do_rd) begin
			flag_rd_s1 <= flags_mem[top_addr][slot];
		end
	end

	// slot value memory
	always_ff @(posedge clk) begin
		if (do_wr) begin
			values_mem[top_addr][slot] <= cmd.binding_value;
		end
		if (do_rd) begin
			val_rd_s1 <= values_mem[top_addr][slot];
		end
	end

	// stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd_fire) begin
			valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_fire) begin
			rd_s1  <= is_rd;
			ofs_s1 <= is_ofs;
			priority if (err_stack) begin
				err_s1 <= ST_STACK;
			end else if (err_range) begin
				err_s1 <= ST_RANGE;
			end else begin
				err_s1 <= ST_OK;
			end
		end
	end

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (s1_adv) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			priority if (err_s1 != ST_OK) begin
				status_q <= err_s1;
				value_q  <= '0;
			end else if (rd_s1) begin
				// unbound, or bound but holding the unbound mark
				if (!flag_rd_s1 || val_rd_s1 == UNBOUND_MARK) begin
					status_q <= ST_UNBOUND;
					value_q  <= '0;
				end else begin
					status_q <= ST_OK;
					value_q  <= val_rd_s1;
				end
			end else if (ofs_s1) begin
				status_q <= ST_OK;
				value_q  <= {{(VALUE_W - OFFSET_W){1'b0}}, ofs_rd_s1};
			end else begin
				status_q <= ST_OK;
				value_q  <= '0;
			end
		end
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.status     = status_q;
	assign rsp.read_value = value_q;

	`CFSB_ASSERT(a_count_range, frame_count_q <= CW'(FRAME_DEPTH), "frame count past depth")
	`CFSB_ASSERT_NEXT(a_count_idle, !cmd_fire, $stable(frame_count_q), "count moved without transfer")
	`CFSB_ASSERT(a_err_zero, !rsp_valid_q || status_q == ST_OK || value_q == '0, "error with value")
	`CFSB_ASSERT(a_stall_blocks, !(valid_s1 && rsp_valid_q && !rsp.ready) || !cmd.ready, "overrun")

endmodule

// ===== dv/tb_call_frame_stack_with_bindings_top.sv =====
// self-checking testbench for call_frame_stack_with_bindings_top
module tb_call_frame_stack_with_bindings_top;
	import cfsb_pkg::*;

	localparam int DEPTH = FRAME_DEPTH_DEF;
	localparam int SLOTS = SLOTS_PER_FRAME_DEF;

	// opcodes the block ignores
	localparam logic [OPCODE_W-1:0] OP_SPARE_LO  = 3'd5;
	localparam logic [OPCODE_W-1:0] OP_SPARE_MID = 3'd6;
	localparam logic [OPCODE_W-1:0] OP_SPARE_HI  = 3'd7;

	// idle tail run after every reply is in, before the verdict is printed
	localparam int TAIL_CYCLES = 10;
	// receiver hold-off long enough to back the block up into its command port
	localparam int LONG_HOLD = 60;

	typedef struct {
		status_t            status;
		logic [VALUE_W-1:0] value;
	} frame_reply_t;

	logic clk;
	logic arst_n;

	cfsb_cmd_if cmd_bus ();
	cfsb_rsp_if rsp_bus ();

	call_frame_stack_with_bindings_top DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_bus),
		.rsp    (rsp_bus)
	);

	// shadow copy of the frame stack, updated at each command transfer
	int unsigned          depth_now;
	logic [OFFSET_W-1:0]  ofs_mem   [DEPTH];
	logic [SLOTS-1:0]     bound_mem [DEPTH];
	logic [VALUE_W-1:0]   slot_mem  [DEPTH][SLOTS];

	// replies owed by the block, oldest first
	frame_reply_t pending_replies [$];

	int  error_count;
	bit  idle_on;      // random gaps on both channels
	int  hold_len;     // request for a long receiver hold-off, in cycles

	// clock: period of 2
	initial clk = 1'b0;
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// generous time limit, far above the slowest legal run
	initial begin
		#200000;
		$display("Simulation FAILED");
		$finish;
	end

	// apply one command to the shadow stack and return the reply it owes
	function automatic frame_reply_t step_frame_stack(logic [OPCODE_W-1:0] opc,
		logic [OFFSET_W-1:0] ofs, logic [INDEX_W-1:0] idx, logic [VALUE_W-1:0] val);
		frame_reply_t rec;
		int unsigned  top;
		rec.status = ST_OK;
		rec.value  = '0;
		case (opc)
			OP_PUSH: begin
				if (depth_now >= DEPTH) begin
					rec.status = ST_STACK;
				end else begin
					ofs_mem[depth_now]   = ofs;
					bound_mem[depth_now] = '0;
					depth_now++;
				end
			end
			OP_POP, OP_READ, OP_WRITE, OP_READ_OFS: begin
				top = depth_now - 1;
				// empty stack wins over every other check
				if (depth_now == 0) begin
					rec.status = ST_STACK;
				end else if (opc == OP_POP) begin
					depth_now--;
				end else if (opc == OP_READ_OFS) begin
					rec.value = {{(VALUE_W-OFFSET_W){1'b0}}, ofs_mem[top]};
				end else if (idx >= SLOTS) begin
					rec.status = ST_RANGE;
				end else if (opc == OP_WRITE) begin
					slot_mem[top][idx]  = val;
					bound_mem[top][idx] = 1'b1;
				end else if (!bound_mem[top][idx] || slot_mem[top][idx] == UNBOUND_MARK) begin
					// all-ones counts as unbound even when the flag is set
					rec.status = ST_UNBOUND;
				end else begin
					rec.value = slot_mem[top][idx];
				end
			end
			default: ;  // spare opcodes: ok, zero, no state change
		endcase
		return rec;
	endfunction

	task automatic report_mismatch(string what, logic [VALUE_W-1:0] got,
		logic [VALUE_W-1:0] want);
		$display("[%0t] mismatch on %s: got %h, expected %h", $time, what, got, want);
		error_count++;
	endtask

	// offer one command from a falling edge until a transfer happens
	task automatic send_cmd(logic [OPCODE_W-1:0] opc, logic [OFFSET_W-1:0] ofs,
		logic [INDEX_W-1:0] idx, logic [VALUE_W-1:0] val);
		@(negedge clk);
		if (idle_on && $urandom_range(0, 4) == 0) begin
			cmd_bus.valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(negedge clk);
		end
		cmd_bus.valid         <= 1'b1;
		cmd_bus.opcode        <= opc;
		cmd_bus.frame_offset  <= ofs;
		cmd_bus.binding_index <= idx;
		cmd_bus.binding_value <= val;
		do @(posedge clk); while (!cmd_bus.ready);
		// transfer happened at this edge
		pending_replies.push_back(step_frame_stack(opc, ofs, idx, val));
	endtask

	// drop valid and wait for every owed reply
	task automatic await_replies();
		@(negedge clk);
		cmd_bus.valid <= 1'b0;
		while (pending_replies.size() != 0) @(posedge clk);
	endtask

	function automatic logic [VALUE_W-1:0] pick_value();
		case ($urandom_range(0, 9))
			0: return UNBOUND_MARK;
			1: return 32'h8000_0000;
			2: return 32'h7FFF_FFFF;
			3: return '0;
			default: return $urandom();
		endcase
	endfunction

	function automatic logic [INDEX_W-1:0] pick_index();
		if ($urandom_range(0, 99) < 85)
			return INDEX_W'($urandom_range(0, SLOTS - 1));
		return INDEX_W'($urandom_range(SLOTS, 255));
	endfunction

	function automatic logic [OFFSET_W-1:0] pick_offset();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			default: return OFFSET_W'($urandom());
		endcase
	endfunction

	// push/pop weights follow the depth so the stack wanders but keeps frames
	function automatic logic [OPCODE_W-1:0] pick_opcode();
		int r;
		int push_w;
		int pop_w;
		r      = $urandom_range(0, 99);
		push_w = (depth_now < 3) ? 30 : ((depth_now > DEPTH - 4) ? 8 : 14);
		pop_w  = (depth_now < 3) ? 6 : ((depth_now > DEPTH - 4) ? 30 : 12);
		if (r < 3)
			return OPCODE_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
		if (r < 3 + push_w)
			return OP_PUSH;
		if (r < 3 + push_w + pop_w)
			return OP_POP;
		case ($urandom_range(0, 9))
			0: return OP_READ_OFS;
			1, 2, 3, 4: return OP_WRITE;
			default: return OP_READ;
		endcase
	endfunction

	// reply checker: compare each reply transfer with the oldest owed reply
	always @(posedge clk) begin
		frame_reply_t want;
		if (arst_n && rsp_bus.valid && rsp_bus.ready) begin
			if (pending_replies.size() == 0) begin
				report_mismatch("reply with no command pending", rsp_bus.read_value, '0);
			end else begin
				want = pending_replies.pop_front();
				if (rsp_bus.status !== want.status)
					report_mismatch("status", VALUE_W'(rsp_bus.status), VALUE_W'(want.status));
				if (rsp_bus.read_value !== want.value)
					report_mismatch("read_value", rsp_bus.read_value, want.value);
			end
		end
	end

	// receiver: random hold-offs, plus the long one on request
	initial begin
		int n;
		rsp_bus.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_len != 0) begin
				rsp_bus.ready <= 1'b0;
				n = hold_len;
				hold_len = 0;
				// count the hold-off out cycle by cycle
				for (int k = 1; k < n; k++) @(negedge clk);
			end else if (idle_on && $urandom_range(0, 4) == 0) begin
				rsp_bus.ready <= 1'b0;
				repeat ($urandom_range(0, 11)) @(negedge clk);
			end else begin
				rsp_bus.ready <= 1'b1;
			end
		end
	end

	// every non-push command on an empty stack, plus a spare opcode
	task automatic test_empty_stack();
		send_cmd(OP_POP, '0, '0, '0);
		send_cmd(OP_READ, '0, 8'd0, '0);
		send_cmd(OP_WRITE, '0, 8'd1, 32'h1234_5678);
		// empty check comes before the range check
		send_cmd(OP_READ, '0, 8'd255, '0);
		send_cmd(OP_READ_OFS, '0, '0, '0);
		send_cmd(OP_SPARE_LO, '1, '1, '1);
	endtask

	// field extremes, bound and unbound reads, range errors, frame isolation
	task automatic test_bindings();
		send_cmd(OP_PUSH, 24'hFF_FFFF, '0, '0);
		send_cmd(OP_READ_OFS, '0, '0, '0);
		send_cmd(OP_READ, '0, 8'd0, '0);                  // never written: unbound
		send_cmd(OP_WRITE, '0, 8'd0, 32'h8000_0000);
		send_cmd(OP_READ, '0, 8'd0, '0);
		send_cmd(OP_WRITE, '0, 8'(SLOTS - 1), 32'h7FFF_FFFF);
		send_cmd(OP_READ, '0, 8'(SLOTS - 1), '0);
		send_cmd(OP_WRITE, '0, 8'd3, UNBOUND_MARK);       // stored, reads as unbound
		send_cmd(OP_READ, '0, 8'd3, '0);
		send_cmd(OP_WRITE, '0, 8'(SLOTS), 32'h0000_0001); // out of range, dropped
		send_cmd(OP_READ, '0, 8'd0, '0);                  // slot 0 must be untouched
		send_cmd(OP_WRITE, '0, 8'd255, '1);
		send_cmd(OP_READ, '0, 8'(SLOTS), '0);
		send_cmd(OP_SPARE_MID, '0, '0, '0);
		send_cmd(OP_SPARE_HI, '1, '1, '1);
		send_cmd(OP_PUSH, 24'h00_0000, '0, '0);
		send_cmd(OP_READ_OFS, '0, '0, '0);
		send_cmd(OP_READ, '0, 8'd0, '0);                  // new frame starts unbound
		send_cmd(OP_POP, '0, '0, '0);
		send_cmd(OP_READ, '0, 8'd0, '0);                  // older frame still holds its value
		send_cmd(OP_POP, '0, '0, '0);
	endtask

	// fill to the top, refuse one more push, unwind to empty, then pop once more
	task automatic test_full_stack();
		while (depth_now < DEPTH) begin
			send_cmd(OP_PUSH, pick_offset(), '0, '0);
			send_cmd(OP_WRITE, '0, INDEX_W'(depth_now % SLOTS), pick_value());
		end
		send_cmd(OP_PUSH, OFFSET_W'($urandom()), '0, '0);
		send_cmd(OP_READ_OFS, '0, '0, '0);
		while (depth_now > 0) begin
			send_cmd(OP_READ_OFS, '0, '0, '0);
			send_cmd(OP_READ, '0, INDEX_W'(depth_now % SLOTS), '0);
			send_cmd(OP_POP, '0, '0, '0);
		end
		send_cmd(OP_POP, '0, '0, '0);
	endtask

	// receiver stalls for a long stretch while commands keep coming
	task automatic test_backpressure();
		send_cmd(OP_PUSH, pick_offset(), '0, '0);
		hold_len = LONG_HOLD;
		repeat (24) begin
			if ($urandom_range(0, 1) == 0)
				send_cmd(OP_WRITE, '0, INDEX_W'($urandom_range(0, SLOTS - 1)), pick_value());
			else
				send_cmd(OP_READ, '0, INDEX_W'($urandom_range(0, SLOTS - 1)), '0);
		end
		// sender pauses until the block has answered everything
		await_replies();
	endtask

	// random command mix biased toward well-formed frame traffic
	task automatic test_random(int count);
		logic [OPCODE_W-1:0] opc;
		repeat (count) begin
			opc = pick_opcode();
			send_cmd(opc, pick_offset(), pick_index(), pick_value());
		end
	endtask

	initial begin
		error_count = 0;
		idle_on     = 1'b1;
		hold_len    = 0;
		depth_now   = 0;
		cmd_bus.valid         = 1'b0;
		cmd_bus.opcode        = '0;
		cmd_bus.frame_offset  = '0;
		cmd_bus.binding_index = '0;
		cmd_bus.binding_value = '0;
		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_empty_stack();
		test_bindings();
		test_full_stack();
		test_backpressure();
		test_random(200);
		await_replies();
		test_random(125);
		// last stretch runs flat out on both sides
		idle_on = 1'b0;
		test_random(100);

		await_replies();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
